// ===== rtl/mbp_pkg.sv =====
// ----------------------------------------------------------------------------
// mbp_pkg
// Shared types and constants for the MP4 box header parser: beat payloads,
// error codes, register indexes and container stack sizing.
// ----------------------------------------------------------------------------
package mbp_pkg;

   // Container stack depth and derived widths
   localparam int MAX_NEST  = 4;
   localparam int LEVEL_W   = $clog2(MAX_NEST + 1);
   localparam int STK_IDX_W = (MAX_NEST > 1) ? $clog2(MAX_NEST) : 1;

   // Header collection
   localparam int          HDR_CNT_W  = 3;
   localparam logic [2:0]  HDR_LAST   = 3'd7;
   localparam logic [31:0] HDR_BYTES  = 32'd8;
   localparam logic [31:0] HDR_BACK   = 32'd7;

   // Box type codes, big-endian ASCII
   localparam logic [31:0] TYPE_MOOF = 32'h6D6F_6F66;
   localparam logic [31:0] TYPE_TRAF = 32'h7472_6166;
   localparam logic [31:0] TYPE_MDAT = 32'h6D64_6174;

   // Register port
   localparam int CSR_IDX_W = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CONTAINER_A = 2'd0,
      CSR_CONTAINER_B = 2'd1
   } csr_index_type;

   typedef enum logic [1:0] {
      ERR_NONE    = 2'd0,
      ERR_SIZE    = 2'd1,
      ERR_OVERRUN = 2'd2,
      ERR_DEPTH   = 2'd3
   } err_code_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       new_buffer;
   } req_type;

   typedef struct packed {
      logic [31:0]  box_type;
      logic [31:0]  box_size;
      logic [31:0]  box_offset;
      logic [2:0]   nest_level;
      logic         is_container;
      logic         is_top_media_data;
      err_code_type error_code;
   } rsp_type;

   // Input stage to parse core
   typedef struct packed {
      logic    advance;
      req_type item;
   } in_stage_type;

   // Parse core to output register
   typedef struct packed {
      logic    emit;
      rsp_type rsp;
   } core_out_type;

endpackage

// ===== rtl/mbp_in_reg.sv =====
// ----------------------------------------------------------------------------
// mbp_in_reg
// Input register: captures one byte beat and hands it to the parse core when
// the output side has room.
// ----------------------------------------------------------------------------
module mbp_in_reg
   import mbp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_type      req_data,
   input  logic         out_free,
   output in_stage_type stage
);

   logic    valid_ff;
   logic    valid_in;
   req_type item_ff;
   logic    advance;
   logic    accept;

   // Move the held beat on whenever the output register can take its result
   assign advance   = valid_ff && out_free;
   assign req_stall = valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Load payload on accept
   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_data;
      end
   end

   assign stage.advance = advance;
   assign stage.item    = item_ff;

endmodule

// ===== rtl/mbp_parse_core.sv =====
// ----------------------------------------------------------------------------
// mbp_parse_core
// Parse state and per-byte logic: header collection, content skipping,
// container end stack, error checks, and the container type registers.
// ----------------------------------------------------------------------------
module mbp_parse_core
   import mbp_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  in_stage_type         stage,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_wdata,
   output core_out_type         core_out
);

   // Configuration registers
   logic [31:0] cont_a_ff;
   logic [31:0] cont_b_ff;

   // Parse state
   logic [31:0]          pos_ff,   pos_in;
   logic [HDR_CNT_W-1:0] hc_ff,    hc_in;
   logic [63:0]          hs_ff,    hs_in;
   logic [LEVEL_W-1:0]   lvl_ff,   lvl_in;
   logic [31:0]          leaf_ff,  leaf_in;
   logic                 inleaf_ff, inleaf_in;
   logic                 err_ff,   err_in;
   logic [31:0]          stack_ff [MAX_NEST];

   // Working signals
   logic [31:0]          e_pos;
   logic [HDR_CNT_W-1:0] e_hc;
   logic [63:0]          e_hs;
   logic [LEVEL_W-1:0]   e_lvl;
   logic [31:0]          e_leaf;
   logic                 e_inleaf;
   logic                 e_err;
   logic [31:0]          next_pos;
   logic [63:0]          shift_new;
   logic [31:0]          box_size;
   logic [31:0]          box_type;
   logic [31:0]          box_offset;
   logic [32:0]          box_end;
   logic                 is_top;
   logic [STK_IDX_W-1:0] top_idx;
   logic [STK_IDX_W-1:0] push_idx;
   logic [31:0]          parent_end;
   logic                 top_mdat;
   logic                 descend;
   logic                 header_done;
   logic                 push;
   logic                 pop_en;
   err_code_type         code;
   logic [31:0]          stk_view [MAX_NEST];
   logic [LEVEL_W-1:0]   lvl_view;
   logic [LEVEL_W-1:0]   lvl_popped;

   assign csr_ready = 1'b1;

   // Container type registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cont_a_ff <= TYPE_MOOF;
         cont_b_ff <= TYPE_TRAF;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_CONTAINER_A: cont_a_ff <= csr_wdata;
            CSR_CONTAINER_B: cont_b_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Clear parse state ahead of the byte on a fresh buffer
   always_comb begin
      e_pos    = pos_ff;
      e_hc     = hc_ff;
      e_hs     = hs_ff;
      e_lvl    = lvl_ff;
      e_leaf   = leaf_ff;
      e_inleaf = inleaf_ff;
      e_err    = err_ff;
      if (stage.item.new_buffer) begin
         e_pos    = '0;
         e_hc     = '0;
         e_hs     = '0;
         e_lvl    = '0;
         e_leaf   = '0;
         e_inleaf = 1'b0;
         e_err    = 1'b0;
      end
   end

   // Decode the header as if this byte completes it
   always_comb begin
      next_pos   = e_pos + 32'd1;
      shift_new  = {e_hs[55:0], stage.item.data_byte};
      box_size   = shift_new[63:32];
      box_type   = shift_new[31:0];
      box_offset = e_pos - HDR_BACK;
      box_end    = {1'b0, box_offset} + {1'b0, box_size};
      is_top     = (e_lvl == '0);
      top_idx    = STK_IDX_W'(e_lvl - LEVEL_W'(1));
      push_idx   = STK_IDX_W'(e_lvl);
      parent_end = stack_ff[top_idx];
      top_mdat   = is_top && (box_type == TYPE_MDAT);
      descend    = !top_mdat && ((box_type == cont_a_ff) || (box_type == cont_b_ff));
   end

   // Error checks in priority order
   always_comb begin
      priority if (box_size < HDR_BYTES) begin
         code = ERR_SIZE;
      end else if (box_end[32]) begin
         code = ERR_OVERRUN;
      end else if (!is_top && (box_end[31:0] > parent_end)) begin
         code = ERR_OVERRUN;
      end else if (descend && (e_lvl >= LEVEL_W'(MAX_NEST))) begin
         code = ERR_DEPTH;
      end else begin
         code = ERR_NONE;
      end
   end

   // Next state for one byte
   always_comb begin
      header_done = 1'b0;
      push        = 1'b0;
      pop_en      = 1'b0;
      pos_in      = next_pos;
      hc_in       = e_hc;
      hs_in       = e_hs;
      leaf_in     = e_leaf;
      inleaf_in   = e_inleaf;
      err_in      = e_err;
      if (e_err) begin
         // hold: bytes ignored until a fresh buffer
      end else if (e_inleaf) begin
         if (next_pos == e_leaf) begin
            inleaf_in = 1'b0;
            pop_en    = 1'b1;
         end
      end else begin
         hs_in = shift_new;
         hc_in = e_hc + HDR_CNT_W'(1);
         if (e_hc == HDR_LAST) begin
            header_done = 1'b1;
            hc_in       = '0;
            if (code != ERR_NONE) begin
               err_in = 1'b1;
            end else if (descend) begin
               push   = 1'b1;
               pop_en = (box_size == HDR_BYTES);
            end else if (box_size == HDR_BYTES) begin
               pop_en = 1'b1;
            end else begin
               inleaf_in = 1'b1;
               leaf_in   = box_end[31:0];
            end
         end
      end
   end

   // Stack after an optional push, then close every container ending here
   always_comb begin
      lvl_view = push ? (e_lvl + LEVEL_W'(1)) : e_lvl;
      for (int i = 0; i < MAX_NEST; i++) begin
         stk_view[i] = (push && (push_idx == STK_IDX_W'(i))) ? box_end[31:0] : stack_ff[i];
      end
      lvl_popped = '0;
      for (int i = 0; i < MAX_NEST; i++) begin
         if ((LEVEL_W'(i) < lvl_view) && (stk_view[i] != next_pos)) begin
            lvl_popped = LEVEL_W'(i + 1);
         end
      end
      lvl_in = pop_en ? lvl_popped : lvl_view;
   end

   // State registers advance with the beat
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         hc_ff     <= '0;
         hs_ff     <= '0;
         lvl_ff    <= '0;
         leaf_ff   <= '0;
         inleaf_ff <= 1'b0;
         err_ff    <= 1'b0;
      end else if (stage.advance) begin
         pos_ff    <= pos_in;
         hc_ff     <= hc_in;
         hs_ff     <= hs_in;
         lvl_ff    <= lvl_in;
         leaf_ff   <= leaf_in;
         inleaf_ff <= inleaf_in;
         err_ff    <= err_in;
      end
   end

   // Container end stack, no reset: only entries below the level are read
   always_ff @(posedge clock) begin
      if (stage.advance && push) begin
         stack_ff[push_idx] <= box_end[31:0];
      end
   end

   // Result for the eighth header byte
   always_comb begin
      core_out.emit                  = stage.advance && header_done;
      core_out.rsp.box_type          = box_type;
      core_out.rsp.box_size          = box_size;
      core_out.rsp.box_offset        = box_offset;
      core_out.rsp.nest_level        = 3'(e_lvl);
      core_out.rsp.is_container      = descend;
      core_out.rsp.is_top_media_data = top_mdat;
      core_out.rsp.error_code        = code;
   end

   // Checks
   a_level_bound : assert property (@(posedge clock) disable iff (reset)
      lvl_ff <= LEVEL_W'(MAX_NEST))
      else $error("open level count beyond stack depth");

   a_leaf_aligned : assert property (@(posedge clock) disable iff (reset)
      inleaf_ff |-> (hc_ff == '0))
      else $error("skipping content with a partial header");

   a_error_latch : assert property (@(posedge clock) disable iff (reset)
      (core_out.emit && (code != ERR_NONE)) |=> err_ff)
      else $error("error result did not latch");

   a_header_restart : assert property (@(posedge clock) disable iff (reset)
      core_out.emit |=> (hc_ff == '0))
      else $error("header count not cleared after result");

endmodule

// ===== rtl/mbp_out_reg.sv =====
// ----------------------------------------------------------------------------
// mbp_out_reg
// Result register: holds one result beat until the consumer takes it.
// ----------------------------------------------------------------------------
module mbp_out_reg
   import mbp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  core_out_type core_out,
   output logic         out_free,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_type      rsp_data
);

   logic    valid_ff;
   logic    valid_in;
   rsp_type data_ff;

   // Free when empty or being drained this cycle
   assign out_free = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff && rsp_stall;
      if (core_out.emit) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Load a new result beat
   always_ff @(posedge clock) begin
      if (core_out.emit) begin
         data_ff <= core_out.rsp;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

// ===== rtl/mp4_box_header_parser.sv =====
// ----------------------------------------------------------------------------
// mp4_box_header_parser
// MP4 box header parser, one buffer byte per beat.
// Registers: the eighth header byte of a box is held in the input register, and
// its result is then loaded into the result register that drives the output.
// Throughput: one byte per cycle, limited only by stalls on the result side.
// Reset: synchronous; clears parse state and restores container types to
// moof and traf. The container end stack is not cleared.
// ----------------------------------------------------------------------------
module mp4_box_header_parser
   import mbp_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_wdata
);

   in_stage_type stage;
   core_out_type core_out;
   logic         out_free;

   mbp_in_reg u_in_reg (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .out_free  (out_free),
      .stage     (stage)
   );

   mbp_parse_core u_core (
      .clock     (clock),
      .reset     (reset),
      .stage     (stage),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .core_out  (core_out)
   );

   mbp_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .core_out  (core_out),
      .out_free  (out_free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the MP4 box header parser. Feeds byte streams built
// from random box trees (containers, leaves, empty boxes, top-level media data)
// with corrupted, truncated and noisy buffers mixed in. An in-bench model of
// the parser predicts every box result, and a monitor checks each result beat
// against the oldest prediction. Both sides idle and stall at random, and the
// container type registers are rewritten between phases.
// ----------------------------------------------------------------------------
module tb;
   import mbp_pkg::*;

   localparam int          WATCHDOG_LIMIT = 2000;
   localparam int          SETTLE_CYCLES  = 8;
   localparam int          PHASE_BYTES    = 380;
   localparam logic [31:0] HEADER_LEN     = 32'd8;
   localparam logic [31:0] CODE_FTYP      = 32'h6674_7970;
   localparam logic [31:0] CODE_FREE      = 32'h6672_6565;
   localparam logic [31:0] CODE_MFHD      = 32'h6D66_6864;
   localparam logic [31:0] CODE_TFHD      = 32'h7466_6864;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   req_type              req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [31:0]          csr_wdata = '0;

   mp4_box_header_parser uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Byte stream waiting to be sent, and box results still owed by the block
   req_type     pending_bytes[$];
   rsp_type     expected_boxes[$];
   int          fail_count = 0;

   // Parser model state
   logic [31:0] ctr_type_a = TYPE_MOOF;
   logic [31:0] ctr_type_b = TYPE_TRAF;
   logic [31:0] stream_pos = '0;
   logic [2:0]  hdr_count = '0;
   logic [63:0] hdr_shift = '0;
   logic [31:0] end_stack[MAX_NEST];
   int          open_cnt = 0;
   logic [31:0] skip_end = '0;
   logic        skipping = 1'b0;
   logic        err_latched = 1'b0;

   // Sender and receiver pacing
   int          burst_left = 0;
   int          gap_left = 0;
   int          stall_mode = 0;
   int          pattern_left = 0;
   logic [3:0]  phase_ctr = '0;
   int          idle_cycles = 0;
   rsp_type     exp_box;

   initial begin
      forever #5 clock = ~clock;
   end

   // Pop every open container that ends at endpos
   function void close_containers(input logic [31:0] endpos);
      while (open_cnt > 0 && end_stack[open_cnt-1] == endpos)
         open_cnt--;
   endfunction

   // Advance the parser model by one byte; queue the box result if one is due
   function void parse_byte(input logic [7:0] data, input logic fresh);
      logic [31:0]  here;
      logic [31:0]  after;
      logic [31:0]  size;
      logic [31:0]  code;
      logic [31:0]  offset;
      logic [32:0]  box_end;
      logic         nested;
      logic         top_mdat;
      logic         descend;
      err_code_type err;
      rsp_type      box;
      if (fresh) begin
         stream_pos  = '0;
         hdr_count   = '0;
         hdr_shift   = '0;
         open_cnt    = 0;
         skip_end    = '0;
         skipping    = 1'b0;
         err_latched = 1'b0;
      end
      here = stream_pos;
      after = here + 32'd1;
      stream_pos = after;
      if (err_latched)
         return;
      // skip leaf content until its last byte
      if (skipping) begin
         if (after == skip_end) begin
            skipping = 1'b0;
            close_containers(after);
         end
         return;
      end
      hdr_shift = {hdr_shift[55:0], data};
      if (hdr_count != 3'd7) begin
         hdr_count = hdr_count + 3'd1;
         return;
      end
      hdr_count = '0;

      size     = hdr_shift[63:32];
      code     = hdr_shift[31:0];
      offset   = here - 32'd7;
      box_end  = {1'b0, offset} + {1'b0, size};
      nested   = (open_cnt != 0);
      top_mdat = !nested && code == TYPE_MDAT;
      descend  = !top_mdat && (code == ctr_type_a || code == ctr_type_b);

      // size first, then overrun, then depth
      err = ERR_NONE;
      if (size < HEADER_LEN)
         err = ERR_SIZE;
      else if (box_end[32])
         err = ERR_OVERRUN;
      else if (nested && box_end[31:0] > end_stack[open_cnt-1])
         err = ERR_OVERRUN;
      else if (descend && open_cnt >= MAX_NEST)
         err = ERR_DEPTH;

      box.box_type          = code;
      box.box_size          = size;
      box.box_offset        = offset;
      box.nest_level        = 3'(open_cnt);
      box.is_container      = descend;
      box.is_top_media_data = top_mdat;
      box.error_code        = err;
      expected_boxes.push_back(box);

      if (err != ERR_NONE) begin
         err_latched = 1'b1;
         return;
      end
      if (descend) begin
         end_stack[open_cnt] = box_end[31:0];
         open_cnt++;
         if (size == HEADER_LEN)
            close_containers(after);
      end else if (size == HEADER_LEN) begin
         close_containers(after);
      end else begin
         skipping = 1'b1;
         skip_end = box_end[31:0];
      end
   endfunction

   // Driver: bursts of beats separated by random gaps; hold payload while stalled
   always @(posedge clock) begin
      if (reset) begin
         req_valid  <= 1'b0;
         burst_left <= 0;
         gap_left   <= 0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid)
            parse_byte(req_data.data_byte, req_data.new_buffer);
         if (gap_left > 0) begin
            gap_left  <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (pending_bytes.size() > 0) begin
            req_valid <= 1'b1;
            req_data  <= pending_bytes.pop_front();
            if (burst_left <= 1) begin
               if ($urandom_range(0, 9) == 0) begin
                  burst_left <= 300;
                  gap_left   <= 0;
               end else begin
                  burst_left <= $urandom_range(1, 24);
                  gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
               end
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: stall pattern switches between free, light, heavy and periodic
   always @(posedge clock) begin
      phase_ctr <= phase_ctr + 4'd1;
      if (reset) begin
         rsp_stall    <= 1'b0;
         pattern_left <= 0;
      end else begin
         if (pattern_left == 0) begin
            stall_mode   <= $urandom_range(0, 3);
            pattern_left <= $urandom_range(20, 200);
         end else begin
            pattern_left <= pattern_left - 1;
         end
         case (stall_mode)
            0: begin
               rsp_stall <= 1'b0;
            end
            1: begin
               rsp_stall <= ($urandom_range(0, 3) == 0);
            end
            2: begin
               rsp_stall <= ($urandom_range(0, 1) == 0);
            end
            default: begin
               rsp_stall <= (phase_ctr < 4'd12);
            end
         endcase
      end
   end

   task check_field(input string field, input logic [31:0] want, input logic [31:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0h, got %0h", field, want, got);
         fail_count++;
      end
   endtask

   // Monitor: compare each result beat with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_boxes.size() == 0) begin
            $error("unexpected result beat: type %0h offset %0h",
                   rsp_data.box_type, rsp_data.box_offset);
            fail_count++;
         end else begin
            exp_box = expected_boxes.pop_front();
            check_field("box_type", exp_box.box_type, rsp_data.box_type);
            check_field("box_size", exp_box.box_size, rsp_data.box_size);
            check_field("box_offset", exp_box.box_offset, rsp_data.box_offset);
            check_field("nest_level", exp_box.nest_level, rsp_data.nest_level);
            check_field("is_container", exp_box.is_container, rsp_data.is_container);
            check_field("is_top_media_data", exp_box.is_top_media_data,
                        rsp_data.is_top_media_data);
            check_field("error_code", exp_box.error_code, rsp_data.error_code);
         end
      end
   end

   // Watchdog: end the run if no beat moves on any channel for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function void queue_byte(input logic [7:0] data, input logic fresh);
      req_type beat;
      beat.data_byte  = data;
      beat.new_buffer = fresh;
      pending_bytes.push_back(beat);
   endfunction

   function void queue_header(input logic [31:0] size, input logic [31:0] code,
                              input logic fresh);
      queue_byte(size[31:24], fresh);
      queue_byte(size[23:16], 1'b0);
      queue_byte(size[15:8], 1'b0);
      queue_byte(size[7:0], 1'b0);
      queue_byte(code[31:24], 1'b0);
      queue_byte(code[23:16], 1'b0);
      queue_byte(code[15:8], 1'b0);
      queue_byte(code[7:0], 1'b0);
   endfunction

   // Build one well-formed box (and its children) at the given depth
   function automatic void append_box(ref logic [7:0] out_q[$], input int depth);
      logic [7:0]  body[$];
      logic [31:0] code;
      logic [31:0] size;
      int          kids;
      int          len;
      int          k;
      if (depth < 6 && $urandom_range(0, 99) < 38 - depth * 4) begin
         code = $urandom_range(0, 1) ? ctr_type_a : ctr_type_b;
         kids = $urandom_range(0, 3);
         for (k = 0; k < kids; k++)
            append_box(body, depth + 1);
      end else begin
         case ($urandom_range(0, 4))
            0: code = TYPE_MDAT;
            1: code = CODE_FTYP;
            2: code = CODE_MFHD;
            3: code = CODE_TFHD;
            default: code = $urandom();
         endcase
         // a leaf whose type would be descended into becomes a free box
         if ((code == ctr_type_a || code == ctr_type_b) && !(depth == 0 && code == TYPE_MDAT))
            code = CODE_FREE;
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(0, 12);
         for (k = 0; k < len; k++)
            body.push_back(8'($urandom_range(0, 255)));
      end
      size = HEADER_LEN + 32'(body.size());
      out_q.push_back(size[31:24]);
      out_q.push_back(size[23:16]);
      out_q.push_back(size[15:8]);
      out_q.push_back(size[7:0]);
      out_q.push_back(code[31:24]);
      out_q.push_back(code[23:16]);
      out_q.push_back(code[15:8]);
      out_q.push_back(code[7:0]);
      foreach (body[i])
         out_q.push_back(body[i]);
   endfunction

   // Random buffers: mostly well-formed trees, some corrupted, some pure noise
   task random_phase(input int n_bytes);
      logic [7:0] box_bytes[$];
      int         sent;
      int         tops;
      int         fresh_at;
      int         pick;
      int         k;
      logic       lead_fresh;
      sent = 0;
      while (sent < n_bytes) begin
         box_bytes.delete();
         fresh_at = -1;
         if ($urandom_range(0, 11) == 0) begin
            pick = $urandom_range(4, 40);
            for (k = 0; k < pick; k++)
               queue_byte(8'($urandom_range(0, 255)), $urandom_range(0, 31) == 0);
            sent += pick;
         end else begin
            tops = $urandom_range(1, 4);
            for (k = 0; k < tops; k++)
               append_box(box_bytes, 0);
            // corrupt a third of the buffers
            case ($urandom_range(0, 11))
               0, 1: begin
                  box_bytes[$urandom_range(0, box_bytes.size() - 1)] =
                     8'($urandom_range(0, 255));
               end
               2: begin
                  pick = $urandom_range(1, box_bytes.size());
                  while (box_bytes.size() > pick)
                     void'(box_bytes.pop_back());
               end
               3: begin
                  fresh_at = $urandom_range(1, box_bytes.size() - 1);
               end
               default: begin
               end
            endcase
            lead_fresh = ($urandom_range(0, 9) != 0);
            foreach (box_bytes[i])
               queue_byte(box_bytes[i], (i == 0) ? lead_fresh : (i == fresh_at));
            sent += box_bytes.size();
         end
      end
   endtask

   task write_csr(input csr_index_type idx, input logic [31:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == CSR_CONTAINER_A)
         ctr_type_a = value;
      else
         ctr_type_b = value;
   endtask

   // Wait until every byte is sent and every result is in, then let the pipe settle
   task wait_idle;
      @(posedge clock);
      while (pending_bytes.size() != 0 || req_valid || expected_boxes.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Empty container, empty top-level mdat, leaf with extreme content bytes
      queue_header(32'd8, TYPE_MOOF, 1'b1);
      queue_header(32'd8, TYPE_MDAT, 1'b0);
      queue_header(32'd12, CODE_FTYP, 1'b0);
      queue_byte(8'h00, 1'b0);
      queue_byte(8'hFF, 1'b0);
      queue_byte(8'h00, 1'b0);
      queue_byte(8'hFF, 1'b0);
      // Nested mdat is a plain leaf; all three boxes close on the same byte
      queue_header(32'd32, TYPE_MOOF, 1'b0);
      queue_header(32'd24, TYPE_TRAF, 1'b0);
      queue_header(32'd16, TYPE_MDAT, 1'b0);
      repeat (8) queue_byte(8'hFF, 1'b0);
      // Fifth nested container is too deep; trailing bytes are ignored
      queue_header(32'd40, TYPE_MOOF, 1'b0);
      queue_header(32'd32, TYPE_TRAF, 1'b0);
      queue_header(32'd24, TYPE_MOOF, 1'b0);
      queue_header(32'd16, TYPE_TRAF, 1'b0);
      queue_header(32'd8, TYPE_MOOF, 1'b0);
      repeat (3) queue_byte(8'hFF, 1'b0);
      // Size below the header length
      queue_header(32'd7, CODE_FREE, 1'b1);
      // Top-level box running past the 32-bit position range
      queue_header(32'd8, CODE_FREE, 1'b1);
      queue_header(32'hFFFF_FFFF, CODE_FREE, 1'b0);
      // Child overrunning its parent
      queue_header(32'd16, TYPE_MOOF, 1'b1);
      queue_header(32'd12, CODE_FREE, 1'b0);
      // Zero size with all-ones type, then a restart in the middle of a header
      queue_header(32'd0, 32'hFFFF_FFFF, 1'b1);
      queue_byte(8'h00, 1'b1);
      queue_byte(8'h00, 1'b0);
      queue_header(32'd8, TYPE_TRAF, 1'b1);
      wait_idle();

      random_phase(PHASE_BYTES);
      wait_idle();

      write_csr(CSR_CONTAINER_A, 32'h0000_0000);
      write_csr(CSR_CONTAINER_B, 32'hFFFF_FFFF);
      random_phase(PHASE_BYTES);
      wait_idle();

      write_csr(CSR_CONTAINER_A, TYPE_MDAT);
      write_csr(CSR_CONTAINER_B, $urandom());
      random_phase(PHASE_BYTES);
      wait_idle();

      write_csr(CSR_CONTAINER_A, TYPE_TRAF);
      write_csr(CSR_CONTAINER_B, TYPE_MOOF);
      random_phase(PHASE_BYTES);
      wait_idle();

      if (fail_count == 0 && expected_boxes.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

// ===== mp4_box_header_parser.f =====
rtl/mbp_pkg.sv
rtl/mbp_in_reg.sv
rtl/mbp_parse_core.sv
rtl/mbp_out_reg.sv
rtl/mp4_box_header_parser.sv
tb/tb.sv
